[rtl/zero_sum_subarray_counter_defines.svh]
// Assertion macros for the zero-sum subarray counter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ZERO_SUM_SUBARRAY_COUNTER_DEFINES_SVH
`define ZERO_SUM_SUBARRAY_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ZSSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("zssc check failed");

// Next-cycle implication, disabled while reset is low.
`define ZSSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("zssc check failed");

`endif

[rtl/zssc_pkg.sv]
// Shared types and constants of the zero-sum subarray counter.
// No dependencies; imported by zero_sum_subarray_counter and its testbench.
package zssc_pkg;

    localparam int VALUE_BITS      = 16;
    localparam int TOTAL_BITS      = 20;
    localparam int EPOCH_BITS      = 8;
    localparam int DEF_MAX_LEN     = 1024;
    localparam int DEF_TABLE_DEPTH = 2048;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } in_beat_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] pair_count;
        logic                  found;
        logic                  end_of_array;
        logic                  too_long;
    } out_beat_t;

endpackage

[rtl/zssc_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies; used for the prefix-sum table.
module zssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/zero_sum_subarray_counter.sv]
// Top level of the zero-sum subarray counter: sequencer, prefix sum and result register.
// Depends on zssc_pkg, zssc_ram and zero_sum_subarray_counter_defines.svh.
//
// Usage
//   s_ channel: one array element per beat (value, last). s_ready is high only
//   while the sequencer is idle, so one element is in work at a time.
//   m_ channel: exactly one result beat per input beat, in order: running count
//   of zero-sum subarrays, found flag, end_of_array (copy of last), too_long.
//   cfg_ channel: one-bit binary_mode; write it only while the block is idle.
//   cfg_ready is always high.
// Sequence
//   An accepted element passes CALC (prefix sum), RD (table read) and CMP
//   (compare, then write) before DONE loads the result register; each extra
//   linear probe repeats RD and CMP. An ignored element past MAX_LEN goes from
//   CALC to DONE. The last element of an array adds a SEED step for sum zero.
//   Table entries carry an epoch tag, so ending an array does not sweep the RAM;
//   a sweep of all TABLE_DEPTH slots runs after reset and once every 255 arrays
//   when the tag wraps. No element is accepted during a sweep.
// Reset and stall
//   aresetn (synchronous, low) clears the array state, binary_mode and the
//   output valid, then starts the sweep. While m_ready is low a finished result
//   waits in the output register and the sequencer holds before going idle.
`include "zero_sum_subarray_counter_defines.svh"

module zero_sum_subarray_counter #(
    parameter int MAX_LEN     = zssc_pkg::DEF_MAX_LEN,
    parameter int TABLE_DEPTH = zssc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  zssc_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output zssc_pkg::out_beat_t m_data
);
    import zssc_pkg::*;

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int CW        = $clog2(MAX_LEN + 1);
    localparam int SUM_BITS  = VALUE_BITS + $clog2(MAX_LEN + 1);
    localparam int CNT_BITS  = $clog2(MAX_LEN + 2);
    localparam int WORD_BITS = EPOCH_BITS + SUM_BITS + CNT_BITS;

    localparam logic [AW:0]           DEPTH_W   = (AW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0]         LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0]         LEN_MAX   = CW'(MAX_LEN);
    localparam logic [EPOCH_BITS-1:0] EPOCH_TOP = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);
    localparam logic [CNT_BITS-1:0]   CNT_ONE   = CNT_BITS'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;
    localparam logic [2:0] ST_SEED  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  found_reg, found_next;
    logic                  m_valid_reg, m_valid_next;

    in_beat_t              in_reg, in_next;
    logic                  over_reg, over_next;
    logic [AW-1:0]         probe_reg, probe_next;
    logic [AW-1:0]         tries_reg, tries_next;
    out_beat_t             out_reg, out_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [EPOCH_BITS-1:0] rd_epoch;
    logic [SUM_BITS-1:0]   rd_sum;
    logic [CNT_BITS-1:0]   rd_cnt;
    logic [SUM_BITS-1:0]   v_ext;
    logic [SUM_BITS-1:0]   sum_new;
    logic [AW:0]           home_raw;
    logic [AW-1:0]         home;
    logic [CNT_BITS-1:0]   prev;
    logic [TOTAL_BITS:0]   total_sum;
    logic                  slot_free;
    logic                  slot_hit;

    assign rd_epoch = ram_rdata[WORD_BITS-1 -: EPOCH_BITS];
    assign rd_sum   = ram_rdata[CNT_BITS +: SUM_BITS];
    assign rd_cnt   = ram_rdata[CNT_BITS-1:0];

    // Stale epoch tag means the slot is empty for this array.
    assign slot_free = (rd_epoch != epoch_reg);
    assign slot_hit  = !slot_free && (rd_sum == sum_reg);

    always_comb begin
        v_ext = {{(SUM_BITS - VALUE_BITS){in_reg.value[VALUE_BITS-1]}}, in_reg.value};
        if (mode_reg && (in_reg.value == '0)) begin
            v_ext = '1;
        end
        sum_new  = sum_reg + v_ext;
        // Any hash works while probing covers the whole table; fold into range.
        home_raw = {1'b0, sum_new[AW-1:0]};
        if (home_raw >= DEPTH_W) begin
            home_raw = home_raw - DEPTH_W;
        end
        home = home_raw[AW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        epoch_next   = epoch_reg;
        clr_next     = clr_reg;
        sum_next     = sum_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        in_next      = in_reg;
        over_next    = over_reg;
        probe_next   = probe_reg;
        tries_next   = tries_reg;
        out_next     = out_reg;
        ram_we       = 1'b0;
        ram_addr     = probe_reg;
        ram_wdata    = {epoch_reg, sum_reg, CNT_ONE};
        prev         = '0;
        total_sum    = '0;

        if (cfg_valid) begin
            mode_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    over_next  = (cnt_reg == LEN_MAX);
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (over_reg) begin
                    state_next = ST_DONE;
                end else begin
                    sum_next   = sum_new;
                    cnt_next   = cnt_reg + CW'(1);
                    probe_next = home;
                    tries_next = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (slot_free || slot_hit) begin
                    ram_we = 1'b1;
                    if (slot_hit) begin
                        prev      = rd_cnt;
                        ram_wdata = {epoch_reg, sum_reg, rd_cnt + CNT_ONE};
                    end
                    state_next = ST_DONE;
                end else if (tries_reg == LAST_SLOT) begin
                    // table full: sum is dropped and adds nothing
                    state_next = ST_DONE;
                end else begin
                    probe_next = (probe_reg == LAST_SLOT) ? '0 : probe_reg + AW'(1);
                    tries_next = tries_reg + AW'(1);
                    state_next = ST_RD;
                end
                if (prev != '0) begin
                    found_next = 1'b1;
                    total_sum  = {1'b0, total_reg} + (TOTAL_BITS + 1)'(prev);
                    total_next = (total_sum > {1'b0, TOTAL_MAX}) ?
                                 TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.pair_count   = total_reg;
                    out_next.found        = found_reg;
                    out_next.end_of_array = in_reg.last;
                    out_next.too_long     = over_reg;
                    m_valid_next          = 1'b1;
                    if (in_reg.last) begin
                        sum_next   = '0;
                        total_next = '0;
                        cnt_next   = '0;
                        found_next = 1'b0;
                        if (epoch_reg == EPOCH_TOP) begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_ONE;
                            state_next = ST_SEED;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_SLOT) begin
                    epoch_next = EPOCH_ONE;
                    state_next = ST_SEED;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_SEED: begin
                // sum zero, count one, at its home slot
                ram_we     = 1'b1;
                ram_addr   = '0;
                ram_wdata  = {epoch_reg, {SUM_BITS{1'b0}}, CNT_ONE};
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            mode_reg    <= 1'b0;
            epoch_reg   <= EPOCH_ONE;
            clr_reg     <= '0;
            sum_reg     <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            epoch_reg   <= epoch_next;
            clr_reg     <= clr_next;
            sum_reg     <= sum_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        over_reg  <= over_next;
        probe_reg <= probe_next;
        tries_reg <= tries_next;
        out_reg   <= out_next;
    end

    zssc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    `ZSSC_ASSERT_NXT(a_accept_to_calc, aclk, aresetn, s_valid && s_ready,
                     state_reg == ST_CALC)
    `ZSSC_ASSERT_IMP(a_found_matches_total, aclk, aresetn, 1'b1,
                     found_reg == (total_reg != '0))
    `ZSSC_ASSERT_IMP(a_len_bound, aclk, aresetn, state_reg == ST_CMP,
                     (cnt_reg != '0) && (cnt_reg <= LEN_MAX))
endmodule

[tb/sv/tb_zero_sum_subarray_counter.sv]
// Self-checking testbench for zero_sum_subarray_counter: directed arrays and random arrays
// under three back-pressure patterns, every result beat checked against a prefix-sum predictor.
// Depends on zssc_pkg and the zero_sum_subarray_counter RTL.
module tb_zero_sum_subarray_counter;
    import zssc_pkg::*;

    localparam int MAX_LEN        = DEF_MAX_LEN;
    localparam int RANDOM_ITEMS   = 700;
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_PRINTS     = 40;
    localparam longint TIMEOUT_NS = 64'd30_000_000;

    localparam logic MODE_PLAIN  = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    typedef enum int {FILL_SMALL, FILL_BITS, FILL_ALIASED, FILL_WIDE, FILL_EXTREMES} fill_e;

    logic      aclk;
    logic      aresetn;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    // predictor state
    longint                run_sum;
    int unsigned           sum_seen [longint];
    logic [TOTAL_BITS-1:0] zero_sum_total;
    int unsigned           array_len;
    logic                  any_zero_sum;
    logic                  binary_mode;

    out_beat_t expected_q [$];
    out_beat_t want_beat;

    int src_idle_pct;
    int snk_idle_pct;
    int elements_sent;
    int arrays_sent;
    int binary_arrays;
    int over_bound_beats;
    int results_checked;
    int mismatches;

    zero_sum_subarray_counter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("zero_sum_subarray_counter: mismatch");
        $finish;
    end

    function automatic void clear_array_state();
        run_sum = 0;
        sum_seen.delete();
        sum_seen[0] = 1;
        zero_sum_total = '0;
        array_len = 0;
        any_zero_sum = 1'b0;
    endfunction

    function automatic out_beat_t count_zero_sums(input in_beat_t beat);
        out_beat_t   res;
        longint      v;
        int unsigned prior;
        logic        over;
        over = (array_len >= MAX_LEN);
        if (!over) begin
            v = longint'(beat.value);
            if (binary_mode == MODE_BINARY && v == 0) v = -1;
            run_sum += v;
            array_len++;
            prior = sum_seen.exists(run_sum) ? sum_seen[run_sum] : 0;
            sum_seen[run_sum] = prior + 1;
            if (prior > 0) begin
                any_zero_sum = 1'b1;
                if (prior >= TOTAL_MAX - zero_sum_total) zero_sum_total = TOTAL_MAX;
                else zero_sum_total = zero_sum_total + TOTAL_BITS'(prior);
            end
        end
        res.pair_count   = zero_sum_total;
        res.found        = any_zero_sum;
        res.end_of_array = beat.last;
        res.too_long     = over;
        if (over) over_bound_beats++;
        if (beat.last) begin
            arrays_sent++;
            if (binary_mode == MODE_BINARY) binary_arrays++;
            clear_array_state();
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH result %0d at %0t: %s", results_checked, $realtime, what);
    endtask

    // result beats are compared in order against the oldest outstanding prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want_beat = expected_q.pop_front();
                if (m_data.pair_count !== want_beat.pair_count)
                    report_mismatch($sformatf("pair_count %0d, want %0d",
                                              m_data.pair_count, want_beat.pair_count));
                if (m_data.found !== want_beat.found)
                    report_mismatch($sformatf("found %b, want %b",
                                              m_data.found, want_beat.found));
                if (m_data.end_of_array !== want_beat.end_of_array)
                    report_mismatch($sformatf("end_of_array %b, want %b",
                                              m_data.end_of_array, want_beat.end_of_array));
                if (m_data.too_long !== want_beat.too_long)
                    report_mismatch($sformatf("too_long %b, want %b",
                                              m_data.too_long, want_beat.too_long));
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_element(input logic signed [VALUE_BITS-1:0] value, input logic last);
        in_beat_t beat;
        beat.value = value;
        beat.last  = last;
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(count_zero_sums(beat));
        elements_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // all results back, the table seed done, and no sweep running
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        wait_drained();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        binary_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_array();
        int unsigned                  len;
        int unsigned                  pick;
        fill_e                        fill;
        logic signed [VALUE_BITS-1:0] v;
        pick = $urandom_range(99);
        if (pick < 55) len = $urandom_range(3, 1);
        else if (pick < 85) len = $urandom_range(12, 4);
        else len = $urandom_range(40, 13);
        fill = fill_e'($urandom_range(FILL_EXTREMES));
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_SMALL:   v = VALUE_BITS'(int'($urandom_range(6)) - 3);
                FILL_BITS:    v = VALUE_BITS'($urandom_range(1));
                // distinct sums sharing a home slot force linear probes
                FILL_ALIASED: v = VALUE_BITS'((int'($urandom_range(8)) - 4) * 2048);
                FILL_WIDE:    v = VALUE_BITS'($urandom());
                default: begin
                    case ($urandom_range(4))
                        0:       v = 16'sh7fff;
                        1:       v = 16'sh8000;
                        2:       v = -1;
                        3:       v = 1;
                        default: v = 0;
                    endcase
                end
            endcase
            send_element(v, i == len - 1);
        end
    endtask

    task automatic test_field_extremes();
        set_mode(MODE_PLAIN);
        send_element(16'sh7fff, 1'b0);
        send_element(16'sh8000, 1'b0);
        send_element(1, 1'b0);
        send_element(0, 1'b0);
        send_element(16'sh8000, 1'b1);
    endtask

    task automatic test_aliased_sums();
        send_element(2048, 1'b0);
        send_element(2048, 1'b0);
        send_element(-4096, 1'b0);
        send_element(4096, 1'b0);
        send_element(-2048, 1'b1);
    endtask

    task automatic test_single_arrays();
        send_element(0, 1'b1);
        send_element(7, 1'b1);
        send_element(-1, 1'b1);
    endtask

    task automatic test_binary_mode();
        set_mode(MODE_BINARY);
        send_element(0, 1'b0);
        send_element(1, 1'b0);
        send_element(0, 1'b0);
        send_element(1, 1'b0);
        send_element(1, 1'b0);
        send_element(0, 1'b0);
        // values other than zero are summed as they are
        send_element(2, 1'b0);
        send_element(-2, 1'b0);
        send_element(0, 1'b1);
    endtask

    task automatic test_random_arrays(input int src_pct, input int snk_pct, input logic mode,
                                      input int target);
        int start;
        set_mode(mode);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start = elements_sent;
        while (elements_sent - start < target) send_random_array();
    endtask

    // all-zero array drives the total to its peak, then beats past the bound are ignored
    task automatic test_length_bound();
        set_mode(MODE_PLAIN);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (MAX_LEN) send_element(0, 1'b0);
        send_element(3, 1'b0);
        send_element(16'sh8000, 1'b1);
        send_element(0, 1'b1);
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        src_idle_pct = 35;
        snk_idle_pct = 79;
        elements_sent    = 0;
        arrays_sent      = 0;
        binary_arrays    = 0;
        over_bound_beats = 0;
        results_checked  = 0;
        mismatches       = 0;
        binary_mode      = MODE_PLAIN;
        clear_array_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_aliased_sums();
        test_single_arrays();
        test_binary_mode();
        test_random_arrays(35, 79, MODE_PLAIN, RANDOM_ITEMS / 3);
        test_random_arrays(79, 35, MODE_BINARY, RANDOM_ITEMS / 3);
        test_random_arrays(0, 0, MODE_PLAIN, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        test_length_bound();
        wait_drained();

        $display("Covered %0d elements in %0d arrays (%0d in binary mode), %0d past the bound;",
                 elements_sent, arrays_sent, binary_arrays, over_bound_beats);
        $display("%0d result beats compared, %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("zero_sum_subarray_counter: match");
        end else begin
            $display("zero_sum_subarray_counter: mismatch");
        end
        $finish;
    end

endmodule
